// ----- rtl/core/fsdp_pkg.sv -----
// Package for the FLV stream demux parser: parse phases, payload kinds,
// container constants and the result record type. No dependencies.
package fsdp_pkg;

    typedef enum logic [2:0] {
        PH_SIG   = 3'd0,
        PH_HDR   = 3'd1,
        PH_EXT   = 3'd2,
        PH_TSIZE = 3'd3,
        PH_THDR  = 3'd4,
        PH_TDATA = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_AUDIO_CFG   = 2'd0,
        KIND_AUDIO_FRAME = 2'd1,
        KIND_VIDEO_CFG   = 2'd2,
        KIND_VIDEO_FRAME = 2'd3
    } kind_t;

    localparam logic [7:0]  SIG_F         = 8'h46;
    localparam logic [7:0]  SIG_L         = 8'h4C;
    localparam logic [7:0]  SIG_V         = 8'h56;
    localparam logic [1:0]  SIG_LEN       = 2'd3;
    localparam logic [31:0] FILE_HDR_LEN  = 32'd9;
    localparam logic [31:0] HDR_LEN_START = 32'd5;
    localparam logic [31:0] TSIZE_LEN     = 32'd4;
    localparam logic [31:0] THDR_LEN      = 32'd11;
    localparam logic [7:0]  TAG_AUDIO     = 8'd8;
    localparam logic [7:0]  TAG_VIDEO     = 8'd9;
    localparam logic [3:0]  FMT_AAC       = 4'd10;
    localparam logic [3:0]  CODEC_AVC     = 4'd7;
    localparam logic [7:0]  PKT_CONFIG    = 8'd0;
    localparam logic [7:0]  PKT_FRAME     = 8'd1;
    localparam logic [31:0] AUDIO_DATA_AT = 32'd2;
    localparam logic [31:0] VIDEO_DATA_AT = 32'd5;

    typedef struct packed {
        logic [7:0]  payload_byte;
        kind_t       payload_kind;
        logic [33:0] present_time;
        logic [31:0] decode_time;
        logic        first_of_packet;
        logic        last_of_packet;
    } result_t;

    function automatic logic [7:0] sig_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = SIG_F;
            2'd1:    c = SIG_L;
            default: c = SIG_V;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/fsdp_byte_if.sv -----
// Input channel: one FLV container byte per transfer.
// Depends on nothing.
interface fsdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ----- rtl/core/fsdp_payload_if.sv -----
// Output channel: one elementary stream payload byte with timing per transfer.
// Depends on nothing.
interface fsdp_payload_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [1:0]  payload_kind;
    logic [33:0] present_time;
    logic [31:0] decode_time;
    logic        first_of_packet;
    logic        last_of_packet;

    modport source (output valid, output payload_byte, output payload_kind,
                    output present_time, output decode_time,
                    output first_of_packet, output last_of_packet, input ready);
    modport sink   (input valid, input payload_byte, input payload_kind,
                    input present_time, input decode_time,
                    input first_of_packet, input last_of_packet, output ready);
endinterface

// ----- rtl/core/flv_stream_demux_parser.sv -----
// FLV stream demux parser top level: signature sync, header/tag parsing,
// AAC/AVC payload forwarding. Depends on fsdp_pkg, fsdp_byte_if, fsdp_payload_if.
//
//  channel   dir  width  contents
//  stream    in   8      stream_byte: FLV container byte
//  payload   out  78     payload_byte, payload_kind, present_time, decode_time,
//                        first_of_packet, last_of_packet
//
// One container byte per cycle while stream.ready is high; each result is registered.
// All parsing is done on the incoming byte against the field registers in the
// same cycle; the result lands in the output register or the skid buffer.
// A one-entry skid buffer behind the output register keeps input flowing for one
// more transfer when payload stalls; stream.ready drops only while it is full.
// rst_n is asynchronous; after reset the parser searches for the signature.
module flv_stream_demux_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    fsdp_byte_if.sink             stream,
    fsdp_payload_if.source        payload
);

    fsdp_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]        sync_reg, sync_next;
    logic [31:0]       cnt_reg, cnt_next;
    logic [31:0]       hdr_len_reg, hdr_len_next;
    logic [7:0]        tag_kind_reg, tag_kind_next;
    logic [23:0]       tag_len_reg, tag_len_next;
    logic [31:0]       tag_time_reg, tag_time_next;
    logic [7:0]        codec_reg, codec_next;
    logic [7:0]        subtype_reg, subtype_next;
    logic [23:0]       coff_reg, coff_next;

    fsdp_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              accept, out_fire, emit;
    logic [7:0]        b;
    logic [31:0]       cnt_inc;
    logic [1:0]        sync_base, sync_step;
    logic [31:0]       hdr_shift;
    logic              pkt_ok;

    assign b        = stream.stream_byte;
    assign stream.ready = !skid_valid_reg;
    assign accept   = stream.valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && payload.ready;
    assign cnt_inc  = cnt_reg + 32'd1;

    assign sync_base = (sync_reg == fsdp_pkg::SIG_LEN) ? 2'd0 : sync_reg;
    assign sync_step = (b == fsdp_pkg::sig_char(sync_base)) ? sync_base + 2'd1 :
                       ((b == fsdp_pkg::SIG_F) ? 2'd1 : 2'd0);
    assign hdr_shift = (cnt_reg >= fsdp_pkg::HDR_LEN_START) ?
                       {hdr_len_reg[23:0], b} : hdr_len_reg;
    assign pkt_ok    = (subtype_reg == fsdp_pkg::PKT_CONFIG) ||
                       (subtype_reg == fsdp_pkg::PKT_FRAME);

    always_comb
    begin : next_state
        phase_next    = phase_reg;
        sync_next     = sync_reg;
        cnt_next      = cnt_reg;
        hdr_len_next  = hdr_len_reg;
        tag_kind_next = tag_kind_reg;
        tag_len_next  = tag_len_reg;
        tag_time_next = tag_time_reg;
        codec_next    = codec_reg;
        subtype_next  = subtype_reg;
        coff_next     = coff_reg;
        if (accept)
        begin
            case (phase_reg)
                fsdp_pkg::PH_SIG:
                begin
                    sync_next = sync_step;
                    if (sync_step == fsdp_pkg::SIG_LEN)
                    begin
                        sync_next    = 2'd0;
                        phase_next   = fsdp_pkg::PH_HDR;
                        cnt_next     = 32'd3;
                        hdr_len_next = 32'd0;
                    end
                end
                fsdp_pkg::PH_HDR:
                begin
                    hdr_len_next = hdr_shift;
                    cnt_next     = cnt_inc;
                    if (cnt_inc >= fsdp_pkg::FILE_HDR_LEN)
                    begin
                        cnt_next   = 32'd0;
                        phase_next = (hdr_shift > fsdp_pkg::FILE_HDR_LEN) ?
                                     fsdp_pkg::PH_EXT : fsdp_pkg::PH_TSIZE;
                    end
                end
                fsdp_pkg::PH_EXT:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= hdr_len_reg - fsdp_pkg::FILE_HDR_LEN)
                    begin
                        cnt_next   = 32'd0;
                        phase_next = fsdp_pkg::PH_TSIZE;
                    end
                end
                fsdp_pkg::PH_TSIZE:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= fsdp_pkg::TSIZE_LEN)
                    begin
                        cnt_next   = 32'd0;
                        phase_next = fsdp_pkg::PH_THDR;
                    end
                end
                fsdp_pkg::PH_THDR:
                begin
                    case (cnt_reg[3:0])
                        4'd0:    tag_kind_next = b;
                        4'd1:    tag_len_next  = {b, 16'd0};
                        4'd2:    tag_len_next  = {tag_len_reg[23:16], b, tag_len_reg[7:0]};
                        4'd3:    tag_len_next  = {tag_len_reg[23:8], b};
                        4'd4:    tag_time_next = {8'd0, b, 16'd0};
                        4'd5:    tag_time_next = {tag_time_reg[31:16], b, tag_time_reg[7:0]};
                        4'd6:    tag_time_next = {tag_time_reg[31:8], b};
                        4'd7:    tag_time_next = {b, tag_time_reg[23:0]};
                        default: tag_time_next = tag_time_reg;
                    endcase
                    cnt_next = cnt_inc;
                    if (cnt_inc >= fsdp_pkg::THDR_LEN)
                    begin
                        cnt_next   = 32'd0;
                        phase_next = (tag_len_reg != 24'd0) ?
                                     fsdp_pkg::PH_TDATA : fsdp_pkg::PH_TSIZE;
                    end
                end
                fsdp_pkg::PH_TDATA:
                begin
                    if (cnt_reg == 32'd0)
                        codec_next = b;
                    else if (cnt_reg == 32'd1)
                        subtype_next = b;
                    else if (tag_kind_reg == fsdp_pkg::TAG_VIDEO)
                    begin
                        if (cnt_reg == 32'd2)
                            coff_next = {b, 16'd0};
                        else if (cnt_reg == 32'd3)
                            coff_next = {coff_reg[23:16], b, coff_reg[7:0]};
                        else if (cnt_reg == 32'd4)
                            coff_next = {coff_reg[23:8], b};
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc >= {8'd0, tag_len_reg})
                    begin
                        cnt_next   = 32'd0;
                        phase_next = fsdp_pkg::PH_TSIZE;
                    end
                end
                default:
                begin
                    phase_next = fsdp_pkg::PH_SIG;
                    sync_next  = 2'd0;
                    cnt_next   = 32'd0;
                end
            endcase
        end
    end

    always_comb
    begin : result_logic
        emit                = 1'b0;
        res.payload_byte    = b;
        res.payload_kind    = fsdp_pkg::KIND_AUDIO_CFG;
        res.present_time    = 34'd0;
        res.decode_time     = 32'd0;
        res.first_of_packet = 1'b0;
        res.last_of_packet  = (cnt_inc == {8'd0, tag_len_reg});
        if (accept && phase_reg == fsdp_pkg::PH_TDATA && pkt_ok)
        begin
            if (tag_kind_reg == fsdp_pkg::TAG_AUDIO && cnt_reg >= fsdp_pkg::AUDIO_DATA_AT
                && codec_reg[7:4] == fsdp_pkg::FMT_AAC)
            begin
                emit                = 1'b1;
                res.first_of_packet = (cnt_reg == fsdp_pkg::AUDIO_DATA_AT);
                if (subtype_reg == fsdp_pkg::PKT_FRAME)
                begin
                    res.payload_kind = fsdp_pkg::KIND_AUDIO_FRAME;
                    res.present_time = {2'd0, tag_time_reg};
                    res.decode_time  = tag_time_reg;
                end
            end
            else if (tag_kind_reg == fsdp_pkg::TAG_VIDEO && cnt_reg >= fsdp_pkg::VIDEO_DATA_AT
                     && codec_reg[3:0] == fsdp_pkg::CODEC_AVC)
            begin
                emit                = 1'b1;
                res.first_of_packet = (cnt_reg == fsdp_pkg::VIDEO_DATA_AT);
                res.payload_kind    = fsdp_pkg::KIND_VIDEO_CFG;
                if (subtype_reg == fsdp_pkg::PKT_FRAME)
                begin
                    res.payload_kind = fsdp_pkg::KIND_VIDEO_FRAME;
                    res.present_time = {2'd0, tag_time_reg} + {10'd0, coff_reg};
                    res.decode_time  = tag_time_reg;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_next = 1'b0;
        end
        else if (emit)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_next = 1'b1;
            else
                out_valid_next = 1'b1;
        end
        else if (out_fire)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= fsdp_pkg::PH_SIG;
            sync_reg       <= 2'd0;
            cnt_reg        <= 32'd0;
            hdr_len_reg    <= 32'd0;
            tag_kind_reg   <= 8'd0;
            tag_len_reg    <= 24'd0;
            tag_time_reg   <= 32'd0;
            codec_reg      <= 8'd0;
            subtype_reg    <= 8'd0;
            coff_reg       <= 24'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            sync_reg       <= sync_next;
            cnt_reg        <= cnt_next;
            hdr_len_reg    <= hdr_len_next;
            tag_kind_reg   <= tag_kind_next;
            tag_len_reg    <= tag_len_next;
            tag_time_reg   <= tag_time_next;
            codec_reg      <= codec_next;
            subtype_reg    <= subtype_next;
            coff_reg       <= coff_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_fire)
            out_reg <= skid_reg;
        else if (!skid_valid_reg && emit && (!out_valid_reg || out_fire))
            out_reg <= res;
        if (!skid_valid_reg && emit && out_valid_reg && !out_fire)
            skid_reg <= res;
    end

    assign payload.valid           = out_valid_reg;
    assign payload.payload_byte    = out_reg.payload_byte;
    assign payload.payload_kind    = out_reg.payload_kind;
    assign payload.present_time    = out_reg.present_time;
    assign payload.decode_time     = out_reg.decode_time;
    assign payload.first_of_packet = out_reg.first_of_packet;
    assign payload.last_of_packet  = out_reg.last_of_packet;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_cfg_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        (payload.valid && (payload.payload_kind == fsdp_pkg::KIND_AUDIO_CFG ||
                           payload.payload_kind == fsdp_pkg::KIND_VIDEO_CFG))
        |-> (payload.present_time == 34'd0 && payload.decode_time == 32'd0))
        else $error("config payload carries a timestamp");

    a_pts_not_below_dts: assert property (@(posedge clk) disable iff (!rst_n)
        payload.valid |-> (payload.present_time >= {2'd0, payload.decode_time}))
        else $error("presentation time below decode time");

    a_emit_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase_reg == fsdp_pkg::PH_TDATA && accept))
        else $error("result produced outside tag payload");

endmodule
